FILE: hdl/bf_run_length_tokenizer_unit_assert.svh
// Assertion helpers for the tokenizer.
`ifndef BF_RUN_LENGTH_TOKENIZER_UNIT_ASSERT_SVH
`define BF_RUN_LENGTH_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BFRLT_ASSERT_IMP(name, clk_s, rst_s, pre, post, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define BFRLT_ASSERT_NXT(name, clk_s, rst_s, pre, post, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/bfrlt_pkg.sv
package bfrlt_pkg;

  localparam int SYMBOL_W    = 8;
  localparam int KIND_W      = 4;
  localparam int AMOUNT_W    = 17;
  localparam int LABEL_OUT_W = 16;
  localparam int ERR_W       = 2;
  localparam int SCALE_W     = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd4;
  localparam int unsigned AMOUNT_MAX = 131071;

  localparam int NEST_DEPTH_DEF = 256;
  localparam int LABEL_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Output queue depth, power of two, at least 2.
  localparam int OQ_DEPTH = 4;

  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] SYM_COMMA = 8'h2C;
  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SYM_DOT   = 8'h2E;
  localparam logic [SYMBOL_W-1:0] SYM_LT    = 8'h3C;
  localparam logic [SYMBOL_W-1:0] SYM_GT    = 8'h3E;
  localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h5B;
  localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h5D;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_FWD   = 4'd2,
    OP_BACK  = 4'd3,
    OP_WRITE = 4'd4,
    OP_READ  = 4'd5,
    OP_OPEN  = 4'd6,
    OP_CLOSE = 4'd7,
    OP_EXIT  = 4'd8
  } op_kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_UNCLOSED  = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_CELL = 2'd1,
    RUN_PTR  = 2'd2
  } run_kind_t;

  typedef struct packed {
    op_kind_t                 op_kind;
    logic [AMOUNT_W-1:0]      amount;
    logic [LABEL_OUT_W-1:0]   label_here;
    logic [LABEL_OUT_W-1:0]   label_target;
    err_code_t                error_code;
    logic                     last_of_run;
  } op_rec_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

FILE: hdl/bfrlt_if.sv
interface bfrlt_in_if;
  logic                              valid;
  logic                              ready;
  logic [bfrlt_pkg::SYMBOL_W-1:0]    symbol;
  logic                              end_of_program;

  modport source (output valid, output symbol, output end_of_program, input ready);
  modport sink (input valid, input symbol, input end_of_program, output ready);
endinterface

interface bfrlt_out_if;
  logic                               valid;
  logic                               ready;
  logic [bfrlt_pkg::KIND_W-1:0]       op_kind;
  logic [bfrlt_pkg::AMOUNT_W-1:0]     amount;
  logic [bfrlt_pkg::LABEL_OUT_W-1:0]  label_here;
  logic [bfrlt_pkg::LABEL_OUT_W-1:0]  label_target;
  logic [bfrlt_pkg::ERR_W-1:0]        error_code;
  logic                               last_of_run;

  modport source (output valid, output op_kind, output amount, output label_here,
                  output label_target, output error_code, output last_of_run,
                  input ready);
  modport sink (input valid, input op_kind, input amount, input label_here,
                input label_target, input error_code, input last_of_run,
                output ready);
endinterface

interface bfrlt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfrlt_pkg::SCALE_W-1:0]   pointer_scale;

  modport source (output valid, output pointer_scale, input ready);
  modport sink (input valid, input pointer_scale, output ready);
endinterface

FILE: hdl/bf_run_length_tokenizer_unit.sv
// Run-length tokenizer for a byte-coded tape program.
// Channels: symbols (sink) carries one program byte or an end_of_program
// marker per transfer; ops (source) carries operation records; cfg (sink)
// writes pointer_scale and is always ready.
// Each accepted item yields zero, one or two records: a folded run that the
// item closes, then the item's own operation. last_of_run marks the final
// record of an item.
// Records of an accepted item are written into the output queue and offered
// on ops from there. An item is taken every cycle as long as output drains at
// one record per cycle; items with two records fill the queue faster than
// the single-record output port drains it.
// Loop labels live in a row of NEST_DEPTH stack cells that shift down on a
// '[' that fits and up on a matched ']'; only the top cell is read.
// Reset clears the run accumulator, label counter, nesting depth and the
// output queue and sets pointer_scale to 4; stack cell contents are left as
// they are. When ops stalls, a four-entry queue holds records and symbols
// ready drops once fewer than two entries are free.
`include "bf_run_length_tokenizer_unit_assert.svh"

module bf_run_length_tokenizer_unit #(
  parameter int NEST_DEPTH = bfrlt_pkg::NEST_DEPTH_DEF,
  parameter int LABEL_BITS = bfrlt_pkg::LABEL_BITS_DEF,
  parameter int COUNT_BITS = bfrlt_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bfrlt_in_if.sink     symbols,
  bfrlt_out_if.source  ops,
  bfrlt_cfg_if.sink    cfg
);
  import bfrlt_pkg::*;

  localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
  localparam int MAG_W   = COUNT_BITS - 1;
  localparam int PROD_W  = MAG_W + SCALE_W;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {MAG_W{1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = -CNT_MAX;

  logic [SCALE_W-1:0]            pointer_scale;
  run_kind_t                     run_kind;
  run_kind_t                     run_kind_next;
  logic signed [COUNT_BITS-1:0]  run_count;
  logic signed [COUNT_BITS-1:0]  run_count_next;
  logic [LABEL_BITS-1:0]         next_label;
  logic [LABEL_BITS-1:0]         next_label_next;
  logic [DEPTH_W-1:0]            stack_depth;
  logic [DEPTH_W-1:0]            stack_depth_next;

  logic                          accept;
  logic                          room;
  logic                          at_full;
  logic [LABEL_BITS-1:0]         top_label;
  logic [LABEL_BITS-1:0]         cell_q [NEST_DEPTH];
  stack_ctl_t                    stk_ctl;
  logic                          push_ok;
  logic                          pop_ok;

  // folded run record
  logic                          cnt_neg;
  logic signed [COUNT_BITS-1:0]  cnt_abs;
  logic [MAG_W-1:0]              mag;
  logic [PROD_W-1:0]             prod;
  logic [AMOUNT_W-1:0]           ptr_amt;
  logic                          flush_has;
  op_rec_t                       flush_rec;

  // item decode
  run_kind_t                     cls;
  logic                          step_up;
  logic signed [COUNT_BITS-1:0]  cnt_base;
  logic signed [COUNT_BITS-1:0]  cnt_step;
  logic                          do_flush;
  logic                          op_has;
  op_rec_t                       op_rec;
  logic                          flush_emit;
  logic [1:0]                    push_cnt;
  op_rec_t                       push_a;

  assign accept          = symbols.valid && symbols.ready;
  assign symbols.ready   = room;
  assign cfg.ready       = 1'b1;
  assign at_full         = stack_depth >= DEPTH_W'(NEST_DEPTH);
  assign top_label       = cell_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_scale <= SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      pointer_scale <= cfg.pointer_scale;
    end
  end

  // Pending run as a record; count magnitude stays below 2^MAG_W.
  assign cnt_neg   = run_count[COUNT_BITS-1];
  assign cnt_abs   = cnt_neg ? -run_count : run_count;
  assign mag       = cnt_abs[MAG_W-1:0];
  assign prod      = PROD_W'(mag) * PROD_W'(pointer_scale);
  assign ptr_amt   = (prod > AMOUNT_MAX) ? AMOUNT_W'(AMOUNT_MAX) : AMOUNT_W'(prod);
  assign flush_has = (run_kind != RUN_NONE) && (run_count != '0);

  always_comb begin
    flush_rec              = '0;
    flush_rec.error_code   = ERR_NONE;
    flush_rec.last_of_run  = !op_has;
    if (run_kind == RUN_CELL) begin
      flush_rec.op_kind = cnt_neg ? OP_SUB : OP_ADD;
      flush_rec.amount  = AMOUNT_W'(mag);
    end else begin
      flush_rec.op_kind = cnt_neg ? OP_BACK : OP_FWD;
      flush_rec.amount  = ptr_amt;
    end
  end

  always_comb begin
    cls     = RUN_NONE;
    step_up = 1'b0;
    unique case (symbols.symbol) inside
      SYM_PLUS:  begin cls = RUN_CELL; step_up = 1'b1; end
      SYM_MINUS: begin cls = RUN_CELL; step_up = 1'b0; end
      SYM_GT:    begin cls = RUN_PTR;  step_up = 1'b1; end
      SYM_LT:    begin cls = RUN_PTR;  step_up = 1'b0; end
      default:   begin cls = RUN_NONE; step_up = 1'b0; end
    endcase
  end

  // Saturating run step; a change of run kind starts from zero.
  always_comb begin
    cnt_base = (run_kind != cls) ? '0 : run_count;
    if (step_up) begin
      cnt_step = (cnt_base != CNT_MAX) ? cnt_base + COUNT_BITS'(1) : cnt_base;
    end else begin
      cnt_step = (cnt_base != CNT_MIN) ? cnt_base - COUNT_BITS'(1) : cnt_base;
    end
  end

  always_comb begin
    run_kind_next       = run_kind;
    run_count_next      = run_count;
    next_label_next     = next_label;
    stack_depth_next    = stack_depth;
    do_flush            = 1'b0;
    op_has              = 1'b0;
    push_ok             = 1'b0;
    pop_ok              = 1'b0;
    op_rec              = '0;
    op_rec.op_kind      = OP_EXIT;
    op_rec.error_code   = ERR_NONE;
    op_rec.last_of_run  = 1'b1;

    if (symbols.end_of_program) begin
      do_flush         = 1'b1;
      op_has           = 1'b1;
      op_rec.op_kind   = OP_EXIT;
      if (stack_depth != '0) begin
        op_rec.error_code = ERR_UNCLOSED;
      end
      stack_depth_next = '0;
      next_label_next  = '0;
    end else if (cls != RUN_NONE) begin
      do_flush       = run_kind != cls;
      run_kind_next  = cls;
      run_count_next = cnt_step;
    end else begin
      unique case (symbols.symbol)
        SYM_DOT: begin
          do_flush       = 1'b1;
          op_has         = 1'b1;
          op_rec.op_kind = OP_WRITE;
        end
        SYM_COMMA: begin
          do_flush       = 1'b1;
          op_has         = 1'b1;
          op_rec.op_kind = OP_READ;
        end
        SYM_OPEN: begin
          do_flush       = 1'b1;
          op_has         = 1'b1;
          op_rec.op_kind = OP_OPEN;
          if (at_full) begin
            op_rec.error_code = ERR_OVERFLOW;
          end else begin
            push_ok             = 1'b1;
            op_rec.label_here   = LABEL_OUT_W'(next_label);
            op_rec.label_target = LABEL_OUT_W'(next_label + LABEL_BITS'(1));
            next_label_next     = next_label + LABEL_BITS'(2);
            stack_depth_next    = stack_depth + DEPTH_W'(1);
          end
        end
        SYM_CLOSE: begin
          do_flush       = 1'b1;
          op_has         = 1'b1;
          op_rec.op_kind = OP_CLOSE;
          if (stack_depth == '0) begin
            op_rec.error_code = ERR_UNMATCHED;
          end else begin
            pop_ok              = 1'b1;
            op_rec.label_here   = LABEL_OUT_W'(top_label + LABEL_BITS'(1));
            op_rec.label_target = LABEL_OUT_W'(top_label);
            stack_depth_next    = stack_depth - DEPTH_W'(1);
          end
        end
        default: begin
          do_flush = 1'b0;
        end
      endcase
      if (do_flush) begin
        run_kind_next  = RUN_NONE;
        run_count_next = '0;
      end
    end
    if (symbols.end_of_program) begin
      run_kind_next  = RUN_NONE;
      run_count_next = '0;
    end
  end

  assign flush_emit  = do_flush && flush_has;
  assign push_cnt    = accept ? (2'(flush_emit) + 2'(op_has)) : 2'd0;
  assign push_a      = flush_emit ? flush_rec : op_rec;
  assign stk_ctl.push = accept && push_ok;
  assign stk_ctl.pop  = accept && pop_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind    <= RUN_NONE;
      run_count   <= '0;
      next_label  <= '0;
      stack_depth <= '0;
    end else if (accept) begin
      run_kind    <= run_kind_next;
      run_count   <= run_count_next;
      next_label  <= next_label_next;
      stack_depth <= stack_depth_next;
    end
  end

  for (genvar gi = 0; gi < NEST_DEPTH; gi++) begin : g_cell
    logic [LABEL_BITS-1:0] above;
    logic [LABEL_BITS-1:0] below;
    if (gi == 0) begin : g_top
      assign above = next_label;
    end else begin : g_mid
      assign above = cell_q[gi-1];
    end
    if (gi == NEST_DEPTH - 1) begin : g_bottom
      assign below = cell_q[gi];
    end else begin : g_inner
      assign below = cell_q[gi+1];
    end
    bfrlt_stack_cell #(
      .LABEL_BITS (LABEL_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (stk_ctl),
      .from_above (above),
      .from_below (below),
      .value      (cell_q[gi])
    );
  end

  bfrlt_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (op_rec),
    .room     (room),
    .ops      (ops)
  );

  `BFRLT_ASSERT_IMP(a_depth_bound, clk, rst, 1'b1, stack_depth <= DEPTH_W'(NEST_DEPTH), "nesting depth past stack size")
  `BFRLT_ASSERT_IMP(a_label_even, clk, rst, 1'b1, next_label[0] == 1'b0, "label counter lost even step")
  `BFRLT_ASSERT_NXT(a_push_step, clk, rst, stk_ctl.push, stack_depth == $past(stack_depth) + DEPTH_W'(1), "push did not grow depth")
  `BFRLT_ASSERT_NXT(a_exit_clears, clk, rst, accept && symbols.end_of_program, stack_depth == '0 && next_label == '0, "end of program left state")

endmodule

FILE: hdl/bfrlt_stack_cell.sv
module bfrlt_stack_cell #(
  parameter int LABEL_BITS = bfrlt_pkg::LABEL_BITS_DEF
) (
  input  logic                   clk,
  input  bfrlt_pkg::stack_ctl_t  ctl,
  input  logic [LABEL_BITS-1:0]  from_above,
  input  logic [LABEL_BITS-1:0]  from_below,
  output logic [LABEL_BITS-1:0]  value
);
  import bfrlt_pkg::*;

  // Push shifts the column down, pop shifts it up.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= from_above;
    end else if (ctl.pop) begin
      value <= from_below;
    end
  end

endmodule

FILE: hdl/bfrlt_out_queue.sv
module bfrlt_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_cnt,
  input  bfrlt_pkg::op_rec_t push_a,
  input  bfrlt_pkg::op_rec_t push_b,
  output logic               room,
  bfrlt_out_if.source        ops
);
  import bfrlt_pkg::*;

  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  op_rec_t             entries [OQ_DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [CNT_W-1:0]    count;
  logic                pop;
  op_rec_t             head;

  assign pop  = ops.valid && ops.ready;
  // Room for the worst case of two records from one item.
  assign room = count <= CNT_W'(OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      entries[wptr + PTR_W'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_cnt);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  assign head             = entries[rptr];
  assign ops.valid        = count != '0;
  assign ops.op_kind      = head.op_kind;
  assign ops.amount       = head.amount;
  assign ops.label_here   = head.label_here;
  assign ops.label_target = head.label_target;
  assign ops.error_code   = head.error_code;
  assign ops.last_of_run  = head.last_of_run;

endmodule

FILE: dv/testbench.sv
module testbench;
  import bfrlt_pkg::*;

  localparam int COUNT_MAX   = 2 ** (COUNT_BITS_DEF - 1) - 1;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                end_of_program;
  } prog_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfrlt_in_if  sym_ch ();
  bfrlt_out_if op_ch ();
  bfrlt_cfg_if cfg_ch ();

  bf_run_length_tokenizer_unit uut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .ops     (op_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Tokenizer state as seen from outside
  logic [SCALE_W-1:0]     cell_bytes = SCALE_RESET;
  run_kind_t              run_state  = RUN_NONE;
  int                     run_total  = 0;
  logic [LABEL_OUT_W-1:0] label_next = '0;
  logic [LABEL_OUT_W-1:0] label_stack [NEST_DEPTH_DEF];
  int                     open_depth = 0;

  prog_byte_t prog_bytes [$];
  op_rec_t    step_ops [$];
  op_rec_t    expected_ops [$];

  int unsigned acted_items = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          calm = 1'b0;

  function void add_op(op_kind_t kind, logic [AMOUNT_W-1:0] amount,
                       logic [LABEL_OUT_W-1:0] here, logic [LABEL_OUT_W-1:0] target,
                       err_code_t err);
    op_rec_t rec;
    rec.op_kind      = kind;
    rec.amount       = amount;
    rec.label_here   = here;
    rec.label_target = target;
    rec.error_code   = err;
    rec.last_of_run  = 1'b0;
    step_ops.push_back(rec);
  endfunction

  // Emit the folded run, if it nets to anything, and clear it
  function void close_run();
    int unsigned      mag;
    longint unsigned  scaled;
    if (run_state != RUN_NONE && run_total != 0) begin
      mag = (run_total > 0) ? run_total : -run_total;
      if (run_state == RUN_CELL) begin
        add_op(run_total > 0 ? OP_ADD : OP_SUB, AMOUNT_W'(mag), '0, '0, ERR_NONE);
      end else begin
        scaled = longint'(mag) * cell_bytes;
        if (scaled > AMOUNT_MAX) scaled = AMOUNT_MAX;
        add_op(run_total > 0 ? OP_FWD : OP_BACK, AMOUNT_W'(scaled), '0, '0, ERR_NONE);
      end
    end
    run_state = RUN_NONE;
    run_total = 0;
  endfunction

  function void tokenize(logic [SYMBOL_W-1:0] sym, logic eop);
    run_kind_t kind;
    step_ops.delete();
    if (eop) begin
      close_run();
      add_op(OP_EXIT, '0, '0, '0, open_depth > 0 ? ERR_UNCLOSED : ERR_NONE);
      open_depth = 0;
      label_next = '0;
    end else begin
      case (sym)
        SYM_PLUS, SYM_MINUS, SYM_GT, SYM_LT: begin
          kind = (sym == SYM_PLUS || sym == SYM_MINUS) ? RUN_CELL : RUN_PTR;
          if (run_state != kind) begin
            close_run();
            run_state = kind;
          end
          if (sym == SYM_PLUS || sym == SYM_GT) begin
            if (run_total < COUNT_MAX) run_total++;
          end else if (run_total > -COUNT_MAX) begin
            run_total--;
          end
        end
        SYM_DOT: begin
          close_run();
          add_op(OP_WRITE, '0, '0, '0, ERR_NONE);
        end
        SYM_COMMA: begin
          close_run();
          add_op(OP_READ, '0, '0, '0, ERR_NONE);
        end
        SYM_OPEN: begin
          close_run();
          if (open_depth >= NEST_DEPTH_DEF) begin
            add_op(OP_OPEN, '0, '0, '0, ERR_OVERFLOW);
          end else begin
            label_stack[open_depth] = label_next;
            open_depth++;
            add_op(OP_OPEN, '0, label_next, label_next + 16'd1, ERR_NONE);
            label_next = label_next + 16'd2;
          end
        end
        SYM_CLOSE: begin
          close_run();
          if (open_depth == 0) begin
            add_op(OP_CLOSE, '0, '0, '0, ERR_UNMATCHED);
          end else begin
            open_depth--;
            add_op(OP_CLOSE, '0, label_stack[open_depth] + 16'd1,
                   label_stack[open_depth], ERR_NONE);
          end
        end
        default: ;
      endcase
    end
    if (step_ops.size() > 0) step_ops[step_ops.size() - 1].last_of_run = 1'b1;
    foreach (step_ops[i]) expected_ops.push_back(step_ops[i]);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function void queue_byte(logic [SYMBOL_W-1:0] sym, logic eop);
    prog_byte_t b;
    b.symbol = sym;
    b.end_of_program = eop;
    prog_bytes.push_back(b);
    if (eop || sym inside {SYM_PLUS, SYM_MINUS, SYM_GT, SYM_LT, SYM_DOT, SYM_COMMA,
                           SYM_OPEN, SYM_CLOSE})
      acted_items++;
  endfunction

  function void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endfunction

  // Mostly balanced programs; a few leave brackets open or close too many
  task queue_random_program();
    int n;
    int pick;
    int depth;
    bit lean;
    bit up;
    bit broken;
    depth = 0;
    broken = ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(4, 40)) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(1, 9);
        lean = 1'($urandom_range(0, 1));
        repeat (n) begin
          up = ($urandom_range(0, 4) == 0) ? !lean : lean;
          if (pick < 25) queue_byte(up ? SYM_PLUS : SYM_MINUS, 1'b0);
          else queue_byte(up ? SYM_GT : SYM_LT, 1'b0);
        end
      end else if (pick < 58) begin
        queue_byte(SYM_DOT, 1'b0);
      end else if (pick < 66) begin
        queue_byte(SYM_COMMA, 1'b0);
      end else if (pick < 78) begin
        queue_byte(SYM_OPEN, 1'b0);
        depth++;
      end else if (pick < 90) begin
        if (depth > 0 || broken) begin
          queue_byte(SYM_CLOSE, 1'b0);
          if (depth > 0) depth--;
        end
      end else begin
        queue_byte(SYMBOL_W'($urandom_range(0, 255)), 1'b0);
      end
    end
    if (!broken) repeat (depth) queue_byte(SYM_CLOSE, 1'b0);
    queue_byte(SYMBOL_W'($urandom_range(0, 255)), 1'b1);
  endtask

  task wait_drained();
    do @(negedge clk);
    while (prog_bytes.size() != 0 || sym_ch.valid || expected_ops.size() != 0);
    // bytes that produce nothing may still be inside the block
    repeat (4) @(negedge clk);
  endtask

  task write_scale(logic [SCALE_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.pointer_scale <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cell_bytes = value;
  endtask

  // Symbol driver
  always @(posedge clk) begin
    if (rst) begin
      sym_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (sym_ch.valid && sym_ch.ready) tokenize(sym_ch.symbol, sym_ch.end_of_program);
      if (!sym_ch.valid || sym_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          sym_ch.valid <= 1'b0;
        end else if (prog_bytes.size() > 0) begin
          sym_ch.valid <= 1'b1;
          {sym_ch.symbol, sym_ch.end_of_program} <= prog_bytes.pop_front();
          if (!calm && $urandom_range(0, 15) == 0) in_gap <= $urandom_range(1, 18);
        end else begin
          sym_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Op record monitor
  always @(posedge clk) begin
    op_rec_t want;
    if (rst) begin
      op_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (op_ch.valid && op_ch.ready) begin
        if (expected_ops.size() == 0) begin
          failures++;
          if (failures <= 100) $error("op record with none expected: kind %0d", op_ch.op_kind);
        end else begin
          want = expected_ops.pop_front();
          check_field("op_kind", want.op_kind, op_ch.op_kind);
          check_field("amount", want.amount, op_ch.amount);
          check_field("label_here", want.label_here, op_ch.label_here);
          check_field("label_target", want.label_target, op_ch.label_target);
          check_field("error_code", want.error_code, op_ch.error_code);
          check_field("last_of_run", want.last_of_run, op_ch.last_of_run);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        op_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(0, 17);
        op_ch.ready <= 1'b0;
      end else begin
        op_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [SCALE_W-1:0] phase_scales [7];
    int unsigned target;
    phase_scales = '{3'd2, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1, 3'd7};
    sym_ch.valid = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.end_of_program = 1'b0;
    op_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pointer_scale = SCALE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset scale: folding, zero net run, ignored bytes, nesting, unmatched and
    // unclosed brackets, flush on end
    queue_text("+++->>x<<<.,+-[[]]]<[--");
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);

    // zero scale still emits moves of amount zero
    write_scale(3'd0);
    queue_text(">>+<<<");
    queue_byte(8'h5A, 1'b1);

    // nesting overflow and an unmatched close, then an open loop left at the end
    write_scale(3'd1);
    repeat (NEST_DEPTH_DEF + 1) queue_byte(SYM_OPEN, 1'b0);
    repeat (NEST_DEPTH_DEF + 1) queue_byte(SYM_CLOSE, 1'b0);
    queue_text("[>");
    queue_byte(8'h3F, 1'b1);

    foreach (phase_scales[i]) begin
      write_scale(phase_scales[i]);
      calm = (i == 6);
      target = acted_items + PHASE_ITEMS;
      while (acted_items < target) queue_random_program();
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (expected_ops.size() != 0) begin
      failures++;
      $error("%0d op records never arrived", expected_ops.size());
    end
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bfrlt_pkg.sv
hdl/bfrlt_if.sv
hdl/bfrlt_stack_cell.sv
hdl/bfrlt_out_queue.sv
hdl/bf_run_length_tokenizer_unit.sv
dv/testbench.sv
